// ===== rtl/u8dn_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dn_pkg
// Types, constants and helpers shared by the utf-8 display name checker.
// ----------------------------------------------------------------------------
package u8dn_pkg;

    localparam int ByteW   = 8;
    localparam int ScalarW = 21;

    // byte boundaries
    localparam logic [ByteW-1:0] BYTE_NUL      = 8'h00;
    localparam logic [ByteW-1:0] BYTE_SPACE    = 8'h20;
    localparam logic [ByteW-1:0] BYTE_DEL      = 8'h7F;
    localparam logic [ByteW-1:0] CONT_LO       = 8'h80;
    localparam logic [ByteW-1:0] CONT_HI       = 8'hBF;
    localparam logic [ByteW-1:0] LEAD2_LO      = 8'hC2;
    localparam logic [ByteW-1:0] LEAD2_HI      = 8'hDF;
    localparam logic [ByteW-1:0] LEAD3_LO      = 8'hE0;
    localparam logic [ByteW-1:0] LEAD3_HI      = 8'hEF;
    localparam logic [ByteW-1:0] LEAD4_LO      = 8'hF0;
    localparam logic [ByteW-1:0] LEAD4_HI      = 8'hF4;

    // scalar limits
    localparam logic [ScalarW-1:0] MIN_CLS2    = 21'h00080;
    localparam logic [ScalarW-1:0] MIN_CLS3    = 21'h00800;
    localparam logic [ScalarW-1:0] MIN_CLS4    = 21'h10000;
    localparam logic [ScalarW-1:0] SCALAR_MAX  = 21'h10FFFF;
    localparam logic [ScalarW-1:0] SURR_LO     = 21'h0D800;
    localparam logic [ScalarW-1:0] SURR_HI     = 21'h0DFFF;

    // sequence length classes
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_TWO   = 2'd1;
    localparam logic [1:0] CLS_THREE = 2'd2;
    localparam logic [1:0] CLS_FOUR  = 2'd3;

    // decoder state carried between items
    typedef struct packed {
        logic [1:0]         pending;
        logic [ScalarW-1:0] accum;
        logic [1:0]         cls;
        logic               failed;
        logic               seen;
    } dec_state_t;

    // result of one item
    typedef struct packed {
        logic done;
        logic verdict;
    } dec_result_t;

    // smallest scalar allowed for a sequence class
    function automatic logic [ScalarW-1:0] class_min(input logic [1:0] cls);
        logic [ScalarW-1:0] m;
        unique case (cls)
            CLS_TWO:   m = MIN_CLS2;
            CLS_THREE: m = MIN_CLS3;
            default:   m = MIN_CLS4;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/u8dn_decode.sv =====
// ----------------------------------------------------------------------------
// u8dn_decode
// Next-state and verdict logic for one text byte.
// ----------------------------------------------------------------------------
module u8dn_decode
    import u8dn_pkg::*;
(
    input  dec_state_t       cur_state,
    input  logic [ByteW-1:0] text_byte,
    output dec_state_t       next_state,
    output dec_result_t      result
);

    logic [ScalarW-1:0] acc_shift;
    logic               range_bad;

    // scalar with this continuation byte shifted in
    assign acc_shift = {cur_state.accum[ScalarW-7:0], text_byte[5:0]};

    // completed scalar out of range for its class
    assign range_bad = (acc_shift < class_min(cur_state.cls))
                    || (acc_shift > SCALAR_MAX)
                    || ((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI));

    always_comb begin
        next_state = cur_state;
        result     = '0;
        if (text_byte == BYTE_NUL) begin
            // terminator: report and clear
            result.done    = 1'b1;
            result.verdict = !cur_state.failed && (cur_state.pending == 2'd0)
                             && cur_state.seen;
            next_state     = '0;
        end else if (!cur_state.failed) begin
            if (cur_state.pending != 2'd0) begin
                // continuation byte expected
                if ((text_byte < CONT_LO) || (text_byte > CONT_HI)) begin
                    next_state.failed = 1'b1;
                end else begin
                    next_state.accum   = acc_shift;
                    next_state.pending = cur_state.pending - 2'd1;
                    if (cur_state.pending == 2'd1) begin
                        if (range_bad) begin
                            next_state.failed = 1'b1;
                        end else begin
                            next_state.seen = 1'b1;
                        end
                    end
                end
            end else if (text_byte < CONT_LO) begin
                // plain ascii
                if ((text_byte < BYTE_SPACE) || (text_byte == BYTE_DEL)) begin
                    next_state.failed = 1'b1;
                end else if (text_byte != BYTE_SPACE) begin
                    next_state.seen = 1'b1;
                end
            end else if ((text_byte >= LEAD2_LO) && (text_byte <= LEAD2_HI)) begin
                next_state.accum   = {{(ScalarW-5){1'b0}}, text_byte[4:0]};
                next_state.cls     = CLS_TWO;
                next_state.pending = 2'd1;
            end else if ((text_byte >= LEAD3_LO) && (text_byte <= LEAD3_HI)) begin
                next_state.accum   = {{(ScalarW-4){1'b0}}, text_byte[3:0]};
                next_state.cls     = CLS_THREE;
                next_state.pending = 2'd2;
            end else if ((text_byte >= LEAD4_LO) && (text_byte <= LEAD4_HI)) begin
                next_state.accum   = {{(ScalarW-3){1'b0}}, text_byte[2:0]};
                next_state.cls     = CLS_FOUR;
                next_state.pending = 2'd3;
            end else begin
                // stray continuation or illegal lead
                next_state.failed = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/utf8_display_name_checker.sv =====
// The result of an accepted byte is registered and shown on the master side in the cycle after it is accepted.
// Throughput: one byte per cycle; the decoder state register closes its loop,
// and a stalled sink holds the input through s_tready.
// Reset: aresetn low clears the decoder state and drops m_tvalid.
// A zero byte ends a text; its result carries m_tlast and the verdict.
// ----------------------------------------------------------------------------
// utf8_display_name_checker
// Checks a zero-terminated utf-8 display name one byte per item.
// ----------------------------------------------------------------------------
module utf8_display_name_checker
    import u8dn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_tdata,   // [7:0] text_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] text_valid, [7:1] zero
    output logic             m_tlast    // text_done
);

    dec_state_t  state_reg, state_next;
    dec_result_t result_next;
    dec_result_t result_reg;
    logic        m_valid_reg;
    logic        s_fire;

    u8dn_decode u_decode (
        .cur_state  (state_reg),
        .text_byte  (s_tdata),
        .next_state (state_next),
        .result     (result_next)
    );

    // accept whenever the result slot is free or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // decoder state and result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = result_reg.done;
    assign m_tdata  = {7'b0, result_reg.verdict};

    // a valid verdict only comes with the terminator
    a_verdict_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tlast))
        else $error("verdict without text end");

    // terminator clears the decoder
    a_clear_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_tdata == BYTE_NUL)) |=> (state_reg == '0))
        else $error("state not cleared after terminator");

    // failure is sticky until the terminator
    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && state_reg.failed && (s_tdata != BYTE_NUL)) |=> state_reg.failed)
        else $error("failure flag dropped inside a text");

    // an accepted byte always leaves a result waiting
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid)
        else $error("accepted item produced no result");

    // stall only while a result is held
    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a pending result");

endmodule
